// ----- hdl/xsf_pkg.sv -----
// Package for the XOR sprite frame buffer.
// Shared constants, operation codes, state codes and structs; no dependencies.
`default_nettype none

package xsf_pkg;

  localparam int DEF_SCREEN_WIDTH    = 64;
  localparam int DEF_SCREEN_HEIGHT   = 32;
  localparam int DEF_MAX_SPRITE_ROWS = 16;

  localparam int SPRITE_BITS = 8;
  localparam int ROW_W       = 64;

  typedef enum logic [2:0] {
    OP_CLEAR      = 3'd0,
    OP_SET_PIXEL  = 3'd1,
    OP_READ_PIXEL = 3'd2,
    OP_DRAW_ROW   = 3'd3,
    OP_READ_ROW   = 3'd4
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } mem_ctl_t;

  typedef struct packed {
    logic             pixel_out;
    logic [ROW_W-1:0] row_bits;
    logic             collision;
    logic             sprite_done;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/xsf_mem.sv -----
// Frame memory: one row word per entry, registered read, per-row valid bits.
// A row whose valid bit is clear reads as blank. Uses xsf_pkg.
`default_nettype none

module xsf_mem #(
  parameter int SCREEN_WIDTH  = xsf_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = xsf_pkg::DEF_SCREEN_HEIGHT,
  parameter int ROW_AW        = 5
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire xsf_pkg::mem_ctl_t       ctl,
  input  wire logic [ROW_AW-1:0]       rd_addr,
  input  wire logic [ROW_AW-1:0]       wr_addr,
  input  wire logic [SCREEN_WIDTH-1:0] wr_data,
  output logic      [SCREEN_WIDTH-1:0] rd_data
);
  import xsf_pkg::*;

  logic [SCREEN_WIDTH-1:0]  mem [SCREEN_HEIGHT];
  logic [SCREEN_HEIGHT-1:0] valid_r;
  logic [SCREEN_WIDTH-1:0]  rdata_r;
  logic                     rvalid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rdata_r  <= mem[rd_addr];
      rvalid_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.clr) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rvalid_r ? rdata_r : '0;

endmodule

`default_nettype wire

// ----- hdl/xsf_ctrl.sv -----
// Sequencer for the frame buffer: address wrap, row read, modify, write back.
// Builds sprite masks and the collision flag. Uses xsf_pkg.
`default_nettype none

module xsf_ctrl #(
  parameter int SCREEN_WIDTH    = xsf_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT   = xsf_pkg::DEF_SCREEN_HEIGHT,
  parameter int MAX_SPRITE_ROWS = xsf_pkg::DEF_MAX_SPRITE_ROWS,
  parameter int ROW_AW          = 5,
  parameter int COL_W           = 6
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [2:0]              in_operation,
  input  wire logic [5:0]              in_x,
  input  wire logic [4:0]              in_y,
  input  wire logic                    in_pixel_value,
  input  wire logic [7:0]              in_sprite_byte,
  input  wire logic [3:0]              in_row_index,
  input  wire logic                    in_last_row,
  input  wire logic                    out_free,
  output logic                         res_load,
  output xsf_pkg::result_t             res,
  output xsf_pkg::mem_ctl_t            mem_ctl,
  output logic      [ROW_AW-1:0]       mem_rd_addr,
  output logic      [ROW_AW-1:0]       mem_wr_addr,
  output logic      [SCREEN_WIDTH-1:0] mem_wr_data,
  input  wire logic [SCREEN_WIDTH-1:0] mem_rd_data
);
  import xsf_pkg::*;

  // wrap tables, filled at elaboration
  logic [ROW_AW-1:0] row_tab [64];
  logic [COL_W-1:0]  col_tab [64];

  for (genvar i = 0; i < 64; i++) begin : g_tab
    localparam int RM = i % SCREEN_HEIGHT;
    localparam int CM = i % SCREEN_WIDTH;
    assign row_tab[i] = ROW_AW'(RM);
    assign col_tab[i] = COL_W'(CM);
  end

  state_t                  state_r, state_nxt;
  logic                    coll_r, coll_nxt;
  op_t                     op_r;
  logic [ROW_AW-1:0]       row_r;
  logic [COL_W-1:0]        col_r;
  logic                    val_r;
  logic [7:0]              pat_r;
  logic [3:0]              ridx_r;
  logic                    last_r;

  logic                    accept;
  logic [5:0]              row_idx;
  logic [ROW_AW-1:0]       row_sel;
  logic [SCREEN_WIDTH-1:0] spread;
  logic [SCREEN_WIDTH-1:0] bit_mask;
  logic                    draw_ok;
  logic                    coll_draw;

  assign accept  = in_valid && in_ready;
  assign row_idx = (op_t'(in_operation) == OP_DRAW_ROW) ?
                   (6'(in_y) + 6'(in_row_index)) : 6'(in_y);
  assign row_sel = row_tab[row_idx];
  assign mem_rd_addr = row_sel;
  assign mem_wr_addr = row_r;

  always_comb begin
    logic [COL_W:0] c;
    spread = '0;
    for (int k = 0; k < SPRITE_BITS; k++) begin
      c = {1'b0, col_r} + (COL_W+1)'(k);
      if (c >= (COL_W+1)'(SCREEN_WIDTH)) begin
        c = c - (COL_W+1)'(SCREEN_WIDTH);
      end
      if (pat_r[SPRITE_BITS-1-k]) begin
        spread[c[COL_W-1:0]] = 1'b1;
      end
    end
  end

  assign bit_mask  = SCREEN_WIDTH'(1) << col_r;
  assign draw_ok   = int'(ridx_r) < MAX_SPRITE_ROWS;
  assign coll_draw = ((ridx_r == '0) ? 1'b0 : coll_r) | (|(mem_rd_data & spread));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      coll_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      coll_r  <= coll_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_operation);
      row_r  <= row_sel;
      col_r  <= col_tab[in_x];
      val_r  <= in_pixel_value;
      pat_r  <= in_sprite_byte;
      ridx_r <= in_row_index;
      last_r <= in_last_row;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    coll_nxt      = coll_r;
    in_ready      = 1'b0;
    res_load      = 1'b0;
    res           = '0;
    mem_ctl       = '0;
    mem_wr_data   = mem_rd_data;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        mem_ctl.rd_en = in_valid;
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
          unique case (op_r)
            OP_CLEAR: begin
              mem_ctl.clr = 1'b1;
            end
            OP_SET_PIXEL: begin
              mem_ctl.wr_en = 1'b1;
              mem_wr_data   = val_r ? (mem_rd_data | bit_mask) : (mem_rd_data & ~bit_mask);
            end
            OP_READ_PIXEL: begin
              res.pixel_out = mem_rd_data[col_r];
            end
            OP_DRAW_ROW: begin
              if (draw_ok) begin
                mem_ctl.wr_en = 1'b1;
                mem_wr_data   = mem_rd_data ^ spread;
                coll_nxt      = coll_draw;
              end
              res.collision   = draw_ok ? coll_draw : coll_r;
              res.sprite_done = last_r;
            end
            OP_READ_ROW: begin
              res.row_bits = ROW_W'(mem_rd_data);
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_EXEC)
    else $error("accepted item did not enter execute");

  a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_ctl.wr_en || mem_ctl.clr) |-> res_load)
    else $error("frame write without result load");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> out_free && state_r == ST_EXEC)
    else $error("result loaded into occupied output register");

endmodule

`default_nettype wire

// ----- hdl/xor_sprite_framebuffer_unit.sv -----
// XOR sprite frame buffer, top level. Uses xsf_pkg, xsf_mem, xsf_ctrl.
// The row is read at the item's accepting edge; in execute it is modified, written back
// and the result loaded into the output register, waiting while that register is full.
// No new item is taken until the read-modify-write of its row ends; clear runs the same way.
// Reset (rst_n low, synchronous) clears all per-row valid bits, so the frame
// reads blank at once with no clearing pass, and clears the collision flag.
`default_nettype none

module xor_sprite_framebuffer_unit #(
  parameter int SCREEN_WIDTH    = xsf_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT   = xsf_pkg::DEF_SCREEN_HEIGHT,
  parameter int MAX_SPRITE_ROWS = xsf_pkg::DEF_MAX_SPRITE_ROWS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_operation,
  input  wire logic [5:0]  in_x,
  input  wire logic [4:0]  in_y,
  input  wire logic        in_pixel_value,
  input  wire logic [7:0]  in_sprite_byte,
  input  wire logic [3:0]  in_row_index,
  input  wire logic        in_last_row,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_pixel_out,
  output logic [63:0]      out_row_bits,
  output logic             out_collision,
  output logic             out_sprite_done
);
  import xsf_pkg::*;

  localparam int ROW_AW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int COL_W  = $clog2(SCREEN_WIDTH);

  mem_ctl_t                mem_ctl;
  logic [ROW_AW-1:0]       mem_rd_addr;
  logic [ROW_AW-1:0]       mem_wr_addr;
  logic [SCREEN_WIDTH-1:0] mem_wr_data;
  logic [SCREEN_WIDTH-1:0] mem_rd_data;
  logic                    res_load;
  result_t                 res;
  result_t                 res_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_free;

  xsf_mem #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .ROW_AW        (ROW_AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .rd_addr (mem_rd_addr),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  xsf_ctrl #(
    .SCREEN_WIDTH    (SCREEN_WIDTH),
    .SCREEN_HEIGHT   (SCREEN_HEIGHT),
    .MAX_SPRITE_ROWS (MAX_SPRITE_ROWS),
    .ROW_AW          (ROW_AW),
    .COL_W           (COL_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_x           (in_x),
    .in_y           (in_y),
    .in_pixel_value (in_pixel_value),
    .in_sprite_byte (in_sprite_byte),
    .in_row_index   (in_row_index),
    .in_last_row    (in_last_row),
    .out_free       (out_free),
    .res_load       (res_load),
    .res            (res),
    .mem_ctl        (mem_ctl),
    .mem_rd_addr    (mem_rd_addr),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_data    (mem_rd_data)
  );

  // output register
  assign out_free      = !out_valid_r || out_ready;
  assign out_valid_nxt = res_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_out   = res_r.pixel_out;
  assign out_row_bits    = res_r.row_bits;
  assign out_collision   = res_r.collision;
  assign out_sprite_done = res_r.sprite_done;

endmodule

`default_nettype wire
